>>> design/lpr_pkg.sv
`default_nettype none

package lpr_pkg;

  // Fixed field widths of the ports
  localparam int PageNumW  = 20;
  localparam int FrameIdxW = 3;
  localparam int TotalW    = 32;
  localparam int CfgW      = 4;

  // Defaults for the top-level parameters
  localparam int MaxFramesDef = 8;
  localparam int PageBitsDef  = 20;

  // Depth of the queue between front and back
  localparam int QueueDepth = 2;

  // One page reference as it travels from front to back
  typedef struct packed {
    logic [PageNumW-1:0] page;
    logic                wr;
    logic                last;
  } ref_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BackIdle,
    BackScan,
    BackCommit
  } back_state_e;

  // One result beat
  typedef struct packed {
    logic                 page_fault;
    logic                 write_back;
    logic [FrameIdxW-1:0] frame_index;
    logic [PageNumW-1:0]  evicted_page;
    logic                 evicted_valid;
    logic [TotalW-1:0]    fault_total;
    logic [TotalW-1:0]    writeback_total;
    logic                 is_last;
  } result_t;

endpackage

`default_nettype wire

>>> design/lpr_front.sv
`default_nettype none

module lpr_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [lpr_pkg::PageNumW-1:0] page_number_i,
  input  wire                          is_write_i,
  input  wire                          last_reference_i,
  output logic                         head_valid_o,
  output lpr_pkg::ref_t                head_o,
  input  wire                          pop_i
);
  import lpr_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  ref_t            entries_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;
  logic            pop;

  // Stall while the queue is full
  assign in_stall_o   = (count_q == CntW'(QueueDepth));
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (count_q != '0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = entries_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    unique case ({push, pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= '{page: page_number_i, wr: is_write_i, last: last_reference_i};
    end
  end

endmodule

`default_nettype wire

>>> design/lpr_back.sv
`default_nettype none

module lpr_back #(
  parameter int MAX_FRAMES = lpr_pkg::MaxFramesDef,
  parameter int PAGE_BITS  = lpr_pkg::PageBitsDef
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire  [$clog2(MAX_FRAMES + 1)-1:0]   frames_i,
  input  wire                                 head_valid_i,
  input  wire  lpr_pkg::ref_t                 head_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output lpr_pkg::result_t                    result_o
);
  import lpr_pkg::*;

  localparam int IdxW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CntW  = $clog2(MAX_FRAMES + 1);
  localparam int WideW = (PAGE_BITS > PageNumW) ? PAGE_BITS : PageNumW;
  localparam int FW    = (IdxW > FrameIdxW) ? IdxW : FrameIdxW;

  back_state_e state_q, state_d;

  // Frame table
  logic [PAGE_BITS-1:0] frame_page_q [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] frame_valid_q;
  logic [MAX_FRAMES-1:0] frame_dirty_q;
  logic [IdxW-1:0]      frame_age_q [MAX_FRAMES];

  // Current reference
  logic [PAGE_BITS-1:0] page_q;
  logic                 wr_q;
  logic                 last_q;

  // Scan results
  logic [IdxW-1:0]      idx_q;
  logic                 hit_q, free_q;
  logic [IdxW-1:0]      hit_f_q, hit_age_q, free_f_q;
  logic [IdxW-1:0]      lru_f_q, lru_age_q;
  logic [PAGE_BITS-1:0] lru_page_q;
  logic                 lru_dirty_q;

  logic [TotalW-1:0]    faults_q, faults_d;
  logic [TotalW-1:0]    wbs_q, wbs_d;
  logic                 out_valid_q;
  result_t              result_q;

  logic                 scan_en, commit_en, scan_last;
  logic [PAGE_BITS-1:0] cur_page;
  logic                 cur_valid, cur_dirty;
  logic [IdxW-1:0]      cur_age;
  logic                 scan_hit, scan_free, scan_lru;
  logic                 fill, evict;
  logic [IdxW-1:0]      f_sel, limit;
  logic [WideW-1:0]     in_wide, ev_wide;
  logic [FW-1:0]        f_wide;

  // Sequencer: take a beat, scan the active frames, commit
  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    scan_en   = 1'b0;
    commit_en = 1'b0;
    unique case (state_q)
      BackIdle: begin
        if (head_valid_i) begin
          pop_o   = 1'b1;
          state_d = BackScan;
        end
      end
      BackScan: begin
        scan_en = 1'b1;
        if (scan_last) state_d = BackCommit;
      end
      BackCommit: begin
        if (!out_valid_q || !out_stall_i) begin
          commit_en = 1'b1;
          state_d   = BackIdle;
        end
      end
      default: state_d = BackIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BackIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Frame under inspection this cycle
  assign cur_page  = frame_page_q[idx_q];
  assign cur_valid = frame_valid_q[idx_q];
  assign cur_dirty = frame_dirty_q[idx_q];
  assign cur_age   = frame_age_q[idx_q];
  assign scan_last = ((CntW'(idx_q) + CntW'(1)) == frames_i);
  assign scan_hit  = cur_valid && !hit_q && (cur_page == page_q);
  assign scan_free = !cur_valid && !free_q;
  assign scan_lru  = (idx_q == '0) || (cur_age > lru_age_q);

  assign in_wide = WideW'(head_i.page);

  // Scan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (pop_o) begin
      idx_q  <= '0;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (scan_en) begin
      idx_q <= idx_q + IdxW'(1);
      if (scan_hit)  hit_q  <= 1'b1;
      if (scan_free) free_q <= 1'b1;
    end
  end

  // Latch the reference and the candidates found by the scan
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      page_q <= in_wide[PAGE_BITS-1:0];
      wr_q   <= head_i.wr;
      last_q <= head_i.last;
    end
    if (scan_en) begin
      if (scan_hit) begin
        hit_f_q   <= idx_q;
        hit_age_q <= cur_age;
      end
      if (scan_free) free_f_q <= idx_q;
      if (scan_lru) begin
        lru_f_q     <= idx_q;
        lru_age_q   <= cur_age;
        lru_page_q  <= cur_page;
        lru_dirty_q <= cur_dirty;
      end
    end
  end

  // Choose the frame and the recency limit
  assign fill  = !hit_q && free_q;
  assign evict = !hit_q && !free_q;
  assign f_sel = hit_q ? hit_f_q : (free_q ? free_f_q : lru_f_q);
  assign limit = hit_q ? hit_age_q : lru_age_q;

  // Saturating totals
  always_comb begin
    faults_d = faults_q;
    wbs_d    = wbs_q;
    if (!hit_q && (faults_q != '1)) faults_d = faults_q + TotalW'(1);
    if (evict && lru_dirty_q && (wbs_q != '1)) wbs_d = wbs_q + TotalW'(1);
  end

  // Update recency, valid and dirty marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_valid_q <= '0;
      frame_dirty_q <= '0;
      for (int j = 0; j < MAX_FRAMES; j++) frame_age_q[j] <= '0;
    end else if (commit_en) begin
      for (int j = 0; j < MAX_FRAMES; j++) begin
        if ((IdxW'(j) != f_sel) && frame_valid_q[j] && (fill || (frame_age_q[j] < limit))) begin
          frame_age_q[j] <= frame_age_q[j] + IdxW'(1);
        end
      end
      frame_age_q[f_sel] <= '0;
      if (hit_q) begin
        if (wr_q) frame_dirty_q[f_sel] <= 1'b1;
      end else begin
        frame_valid_q[f_sel] <= 1'b1;
        frame_dirty_q[f_sel] <= wr_q;
      end
    end
  end

  // Write the new page into its frame
  always_ff @(posedge clk_i) begin
    if (commit_en && !hit_q) frame_page_q[f_sel] <= page_q;
  end

  assign ev_wide = WideW'(lru_page_q);
  assign f_wide  = FW'(f_sel);

  // Totals and output flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      faults_q    <= '0;
      wbs_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (commit_en) begin
      faults_q    <= faults_d;
      wbs_q       <= wbs_d;
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result beat
  always_ff @(posedge clk_i) begin
    if (commit_en) begin
      result_q.page_fault      <= !hit_q;
      result_q.write_back      <= evict && lru_dirty_q;
      result_q.frame_index     <= f_wide[FrameIdxW-1:0];
      result_q.evicted_page    <= evict ? ev_wide[PageNumW-1:0] : '0;
      result_q.evicted_valid   <= evict;
      result_q.fault_total     <= faults_d;
      result_q.writeback_total <= wbs_d;
      result_q.is_last         <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

>>> design/lru_page_replacement.sv
// Fully associative LRU page-frame replacement.
// The back end handles one reference at a time: it scans the frame table
// one frame per cycle, then commits, and takes the next reference only
// once the commit is done; the commit waits while a pending result is stalled.
// A two-entry queue takes new references while the back end is busy.
// Reset (asynchronous, active low) empties the frames, clears totals and sets
// the active frame count to MAX_FRAMES; stored page numbers are left as is.
`default_nettype none

module lru_page_replacement #(
  parameter int MAX_FRAMES = lpr_pkg::MaxFramesDef,
  parameter int PAGE_BITS  = lpr_pkg::PageBitsDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [lpr_pkg::CfgW-1:0]     cfg_data_i,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [lpr_pkg::PageNumW-1:0] page_number_i,
  input  wire                          is_write_i,
  input  wire                          last_reference_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic                         page_fault_o,
  output logic                         write_back_o,
  output logic [lpr_pkg::FrameIdxW-1:0] frame_index_o,
  output logic [lpr_pkg::PageNumW-1:0] evicted_page_o,
  output logic                         evicted_valid_o,
  output logic [lpr_pkg::TotalW-1:0]   fault_total_o,
  output logic [lpr_pkg::TotalW-1:0]   writeback_total_o,
  output logic                         is_last_o
);
  import lpr_pkg::*;

  localparam int CntW = $clog2(MAX_FRAMES + 1);

  logic [CntW-1:0] frames_q, frames_d;
  logic            head_valid;
  ref_t            head;
  logic            pop;
  result_t         result;

  // Active frame count, clamped to one through MAX_FRAMES on write
  assign cfg_ready_o = 1'b1;

  always_comb begin
    frames_d = frames_q;
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_data_i == '0) begin
        frames_d = CntW'(1);
      end else if (int'(cfg_data_i) > MAX_FRAMES) begin
        frames_d = CntW'(MAX_FRAMES);
      end else begin
        frames_d = CntW'(cfg_data_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= CntW'(MAX_FRAMES);
    end else begin
      frames_q <= frames_d;
    end
  end

  lpr_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .page_number_i    (page_number_i),
    .is_write_i       (is_write_i),
    .last_reference_i (last_reference_i),
    .head_valid_o     (head_valid),
    .head_o           (head),
    .pop_i            (pop)
  );

  lpr_back #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frames_i     (frames_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_o     (result)
  );

  assign page_fault_o      = result.page_fault;
  assign write_back_o      = result.write_back;
  assign frame_index_o     = result.frame_index;
  assign evicted_page_o    = result.evicted_page;
  assign evicted_valid_o   = result.evicted_valid;
  assign fault_total_o     = result.fault_total;
  assign writeback_total_o = result.writeback_total;
  assign is_last_o         = result.is_last;

  // A hit neither evicts nor writes back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !page_fault_o) |-> (!write_back_o && !evicted_valid_o))
    else $error("hit reported an eviction or writeback");

  // A writeback only comes with an eviction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && write_back_o) |-> evicted_valid_o)
    else $error("writeback without eviction");

  // A fault beat always carries a non-zero fault total
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && page_fault_o) |-> (fault_total_o != '0))
    else $error("fault with zero fault total");

  // A hit straight after a taken beat leaves the fault total unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((out_valid_o && !out_stall_i) ##1 (out_valid_o && !page_fault_o))
      |-> (fault_total_o == $past(fault_total_o)))
    else $error("fault total moved on a hit");

endmodule

`default_nettype wire

>>> tb/lru_page_replacement_test.sv
`default_nettype none

module lru_page_replacement_test;
  import lpr_pkg::*;

  localparam int NumFrames   = MaxFramesDef;
  localparam int IdleLimit   = 2000;
  localparam int DrainCycles = 20;
  localparam int PrintLimit  = 50;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgW-1:0]      cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [PageNumW-1:0]  page_number_i;
  logic                 is_write_i;
  logic                 last_reference_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 page_fault_o;
  logic                 write_back_o;
  logic [FrameIdxW-1:0] frame_index_o;
  logic [PageNumW-1:0]  evicted_page_o;
  logic                 evicted_valid_o;
  logic [TotalW-1:0]    fault_total_o;
  logic [TotalW-1:0]    writeback_total_o;
  logic                 is_last_o;

  // Shadow of the frame table and totals
  logic [PageNumW-1:0]  slot_page  [NumFrames];
  logic                 slot_busy  [NumFrames];
  logic                 slot_dirty [NumFrames];
  logic [FrameIdxW-1:0] slot_rank  [NumFrames];
  logic [TotalW-1:0]    fault_count;
  logic [TotalW-1:0]    wb_count;
  logic [CfgW-1:0]      frames_setting;

  result_t     pending_outcomes[$];
  int unsigned error_count;
  int unsigned burst_left;
  bit          gapless;
  int unsigned idle_cycles;
  logic [8:0]  stall_phase;

  lru_page_replacement u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .page_number_i    (page_number_i),
    .is_write_i       (is_write_i),
    .last_reference_i (last_reference_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .page_fault_o     (page_fault_o),
    .write_back_o     (write_back_o),
    .frame_index_o    (frame_index_o),
    .evicted_page_o   (evicted_page_o),
    .evicted_valid_o  (evicted_valid_o),
    .fault_total_o    (fault_total_o),
    .writeback_total_o(writeback_total_o),
    .is_last_o        (is_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Empty the shadow frame table, as reset does
  function automatic void clear_frame_table();
    int i;
    for (i = 0; i < NumFrames; i++) begin
      slot_page[i]  = '0;
      slot_busy[i]  = 1'b0;
      slot_dirty[i] = 1'b0;
      slot_rank[i]  = '0;
    end
    fault_count    = '0;
    wb_count       = '0;
    frames_setting = CfgW'(NumFrames);
  endfunction

  // Make slot f the most recent; resident slots more recent than limit age by one
  function automatic void promote_slot(int f, int unsigned limit);
    int i;
    for (i = 0; i < NumFrames; i++) begin
      if (i != f && slot_busy[i] && slot_rank[i] < limit) slot_rank[i]++;
    end
    slot_rank[f] = '0;
  endfunction

  // Apply one page reference to the shadow table and return the outcome
  function automatic result_t resolve_reference(logic [PageNumW-1:0] page, logic wr,
                                                logic last);
    result_t r;
    int      n;
    int      i;
    int      slot;
    int      free_slot;
    bit      hit;
    r = '0;
    if (frames_setting == 0) n = 1;
    else if (frames_setting > NumFrames) n = NumFrames;
    else n = frames_setting;
    hit       = 1'b0;
    slot      = 0;
    free_slot = -1;
    // Lowest matching active slot wins; note the lowest free one
    for (i = 0; i < n; i++) begin
      if (slot_busy[i]) begin
        if (!hit && slot_page[i] == page) begin
          hit  = 1'b1;
          slot = i;
        end
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit) begin
      promote_slot(slot, slot_rank[slot]);
      if (wr) slot_dirty[slot] = 1'b1;
    end else begin
      r.page_fault = 1'b1;
      if (fault_count != '1) fault_count++;
      if (free_slot >= 0) begin
        slot = free_slot;
        slot_busy[slot] = 1'b1;
        promote_slot(slot, NumFrames);
      end else begin
        // Evict the lowest-numbered slot of greatest age
        slot = 0;
        for (i = 1; i < n; i++) begin
          if (slot_rank[i] > slot_rank[slot]) slot = i;
        end
        r.evicted_valid = 1'b1;
        r.evicted_page  = slot_page[slot];
        if (slot_dirty[slot]) begin
          r.write_back = 1'b1;
          if (wb_count != '1) wb_count++;
        end
        promote_slot(slot, slot_rank[slot]);
      end
      slot_page[slot]  = page;
      slot_dirty[slot] = wr;
    end
    r.frame_index     = FrameIdxW'(slot);
    r.fault_total     = fault_count;
    r.writeback_total = wb_count;
    r.is_last         = last;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    error_count++;
    if (error_count <= PrintLimit)
      $display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
  endtask

  // Send one reference beat; when the current burst is spent, a random idle gap may come first
  task automatic send_reference(logic [PageNumW-1:0] page, logic wr, logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gapless ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i       <= 1'b1;
    page_number_i    <= page;
    is_write_i       <= wr;
    last_reference_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    pending_outcomes.push_back(resolve_reference(page, wr, last));
  endtask

  // Drop valid, wait for every outcome, then let the back end fall quiet
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_frame_count(logic [CfgW-1:0] value);
    settle_block();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i    <= 1'b0;
    frames_setting = value;
  endtask

  // Fill all eight frames, hit some, then evict clean and dirty pages
  task automatic test_fill_and_hit();
    send_reference(20'h00000, 1'b1, 1'b0);
    send_reference(20'hFFFFF, 1'b0, 1'b0);
    send_reference(20'h00001, 1'b1, 1'b0);
    send_reference(20'h80000, 1'b0, 1'b0);
    send_reference(20'h55555, 1'b1, 1'b0);
    send_reference(20'hAAAAA, 1'b0, 1'b0);
    send_reference(20'h12345, 1'b0, 1'b0);
    send_reference(20'h7FFFF, 1'b1, 1'b0);
    send_reference(20'h00000, 1'b0, 1'b0);
    send_reference(20'hFFFFF, 1'b1, 1'b0);
    send_reference(20'h00001, 1'b0, 1'b0);
    send_reference(20'h33333, 1'b0, 1'b0);
    send_reference(20'h44444, 1'b1, 1'b0);
    send_reference(20'h7FFFF, 1'b0, 1'b1);
  endtask

  // Single frame, zero and oversized counts, and a page held in two frames
  task automatic test_frame_count_limits();
    write_frame_count(CfgW'(1));
    send_reference(20'h00ABC, 1'b1, 1'b0);
    send_reference(20'h00ABC, 1'b0, 1'b0);
    send_reference(20'h00000, 1'b0, 1'b0);
    send_reference(20'h00000, 1'b1, 1'b0);
    send_reference(20'hFFFFF, 1'b0, 1'b1);
    write_frame_count(CfgW'(0));
    send_reference(20'h11111, 1'b1, 1'b0);
    send_reference(20'h11111, 1'b0, 1'b0);
    send_reference(20'hFFFFF, 1'b0, 1'b0);
    write_frame_count(CfgW'(15));
    send_reference(20'hFFFFF, 1'b1, 1'b0);
    send_reference(20'h12345, 1'b0, 1'b0);
    send_reference(20'h0F0F0, 1'b1, 1'b1);
  endtask

  // Phases of random traces over a small working set, one frame count each
  task automatic test_random_traces();
    int                  settings [11] = '{8, 1, 15, 0, 3, 5, 2, 7, 9, 6, 4};
    logic [PageNumW-1:0] pool [16];
    logic [PageNumW-1:0] page;
    int                  p;
    int                  k;
    int                  span;
    for (p = 0; p < 11; p++) begin
      write_frame_count(CfgW'(settings[p]));
      gapless = (p % 3 == 2);
      if (settings[p] == 0) span = 3;
      else if (settings[p] > NumFrames) span = NumFrames + 2;
      else span = settings[p] + 2;
      for (k = 0; k < 16; k++) pool[k] = PageNumW'($urandom);
      for (k = 0; k < 100; k++) begin
        case ($urandom_range(0, 7))
          0:       page = PageNumW'($urandom);
          1, 2:    page = pool[k % (span + 1)];
          default: page = pool[$urandom_range(0, span)];
        endcase
        send_reference(page, 1'($urandom_range(0, 1)), $urandom_range(0, 19) == 0);
      end
    end
    gapless = 1'b0;
  endtask

  // Check each result beat and advance the stall pattern
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected result beat", 0, 0);
      end else begin
        want = pending_outcomes.pop_front();
        if (page_fault_o !== want.page_fault)
          report_mismatch("page_fault", page_fault_o, want.page_fault);
        if (write_back_o !== want.write_back)
          report_mismatch("write_back", write_back_o, want.write_back);
        if (frame_index_o !== want.frame_index)
          report_mismatch("frame_index", frame_index_o, want.frame_index);
        if (evicted_page_o !== want.evicted_page)
          report_mismatch("evicted_page", evicted_page_o, want.evicted_page);
        if (evicted_valid_o !== want.evicted_valid)
          report_mismatch("evicted_valid", evicted_valid_o, want.evicted_valid);
        if (fault_total_o !== want.fault_total)
          report_mismatch("fault_total", fault_total_o, want.fault_total);
        if (writeback_total_o !== want.writeback_total)
          report_mismatch("writeback_total", writeback_total_o, want.writeback_total);
        if (is_last_o !== want.is_last)
          report_mismatch("is_last", is_last_o, want.is_last);
      end
    end
    // Quiet, random and long-stall stretches in turn
    stall_phase <= stall_phase + 1'b1;
    case (stall_phase[8:7])
      2'd0:    out_stall_i <= 1'b0;
      2'd3:    out_stall_i <= (stall_phase[4:0] < 5'd20);
      default: out_stall_i <= 1'($urandom_range(0, 1));
    endcase
  end

  // Count cycles without any beat; give up at the limit
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IdleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    page_number_i    = '0;
    is_write_i       = 1'b0;
    last_reference_i = 1'b0;
    out_stall_i      = 1'b0;
    stall_phase      = '0;
    idle_cycles      = 0;
    error_count      = 0;
    burst_left       = 0;
    gapless          = 1'b0;
    clear_frame_table();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_fill_and_hit();
    test_frame_count_limits();
    test_random_traces();
    settle_block();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
